// ===== rtl/dftd_pkg.sv =====
// ----------------------------------------------------------------------------
// dftd_pkg
// Shared constants, register map and twiddle table functions for the
// direct complex DFT block.
// ----------------------------------------------------------------------------
package dftd_pkg;

  // Default sizing
  localparam int POINTS_DEF       = 64;
  localparam int TWIDDLE_BITS_DEF = 16;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int BIN_W      = 24;
  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = 2 * BIN_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_INVERSE_MODE = '0;

  // Phase constants (turns scaled by 2^32, pi in Q2.30)
  localparam logic [63:0] PI_Q30       = 64'hC90F_DAA2;
  localparam logic [63:0] QUARTER_TURN = 64'h4000_0000;

  // Taylor divisors (2i)(2i+1) for i = 1..7
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // sin of a phase in turns * 2^32, result in Q2.30
  function automatic longint sin_turn(input logic [31:0] p);
    logic [1:0]  q;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    q = p[31:30];
    f = {34'd0, p[29:0]};
    if (q[0]) begin
      f = QUARTER_TURN - f;
    end
    x    = (f * PI_Q30) >> 31;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if ((i & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return q[1] ? -sum : sum;
  endfunction

  // Round half away from zero to Q1.(tw_bits-1), clamp the magnitude
  function automatic logic signed [31:0] to_twiddle(input longint v, input int tw_bits);
    int          s;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] maxv;
    s    = 30 - (tw_bits - 1);
    maxv = (64'd1 << (tw_bits - 1)) - 64'd1;
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    r    = (mag + (64'd1 << (s - 1))) >> s;
    if (r > maxv) begin
      r = maxv;
    end
    return (v < 0) ? -$signed(32'(r)) : $signed(32'(r));
  endfunction

  // Table entry m of a full-turn table with 2^pts_w entries
  function automatic logic signed [31:0] tw_sin(input int m, input int pts_w,
                                                input int tw_bits);
    logic [31:0] p;
    p = 32'(m) << (32 - pts_w);
    return to_twiddle(sin_turn(p), tw_bits);
  endfunction

  function automatic logic signed [31:0] tw_cos(input int m, input int pts_w,
                                                input int tw_bits);
    logic [31:0] p;
    p = (32'(m) << (32 - pts_w)) + 32'(QUARTER_TURN);
    return to_twiddle(sin_turn(p), tw_bits);
  endfunction

endpackage

// ===== rtl/dftd_ram.sv =====
// ----------------------------------------------------------------------------
// dftd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dftd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/direct_dft_forward_inverse.sv =====
// ----------------------------------------------------------------------------
// direct_dft_forward_inverse
// Samples are loaded at one item per cycle; the item marked last starts the
// transform. Each bin runs on the shared complex MAC (one sample per cycle
// through the store RAM and twiddle ROM, then the product and accumulate
// registers) and is then held in the output register until it is taken.
// No sample is taken while bins are being produced. Reset (rst, synchronous)
// empties the sample count, idles the sequencer and selects forward mode.
// POINTS is a power of two.
// ----------------------------------------------------------------------------
module direct_dft_forward_inverse #(
  parameter int POINTS       = dftd_pkg::POINTS_DEF,
  parameter int TWIDDLE_BITS = dftd_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Sample stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dftd_pkg::IN_DATA_W-1:0]  s_tdata,   // sample_real, sample_imag
  input  logic                            s_tlast,   // sample_last
  // Bin stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dftd_pkg::OUT_DATA_W-1:0] m_tdata,   // bin_real, bin_imag
  output logic                            m_tlast,   // bin_last
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dftd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dftd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dftd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import dftd_pkg::*;

  localparam int PTS_W  = $clog2(POINTS);
  localparam int TW_F   = TWIDDLE_BITS - 1;
  localparam int PROD_W = SAMPLE_W + TWIDDLE_BITS;
  localparam int ACC_W  = PROD_W + 1 + PTS_W;

  localparam logic signed [ACC_W-1:0] BIN_HI = ACC_W'((2 ** (BIN_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] BIN_LO = -BIN_HI - ACC_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_t;

  state_t             state;
  logic [PTS_W:0]     load_count;
  logic [PTS_W:0]     count;
  logic [PTS_W-1:0]   n_idx;
  logic [PTS_W-1:0]   k_idx;
  logic [PTS_W-1:0]   m_idx;
  logic               v1;
  logic               v2;
  logic               inverse_mode;

  logic               in_acc;
  logic               store_full;
  logic               k_done;
  logic               drain_done;
  logic               bin_done;

  logic [IN_DATA_W-1:0] rd_word;

  logic signed [TWIDDLE_BITS-1:0] cos_tab [POINTS];
  logic signed [TWIDDLE_BITS-1:0] sin_tab [POINTS];
  logic signed [TWIDDLE_BITS-1:0] cos_q;
  logic signed [TWIDDLE_BITS-1:0] sin_q;

  logic signed [SAMPLE_W-1:0]     op_a;
  logic signed [SAMPLE_W-1:0]     op_b;
  logic signed [TWIDDLE_BITS-1:0] op_d;
  logic signed [PROD_W-1:0]       pr_ac;
  logic signed [PROD_W-1:0]       pr_bd;
  logic signed [PROD_W-1:0]       pr_ad;
  logic signed [PROD_W-1:0]       pr_bc;
  logic signed [ACC_W-1:0]        acc_re;
  logic signed [ACC_W-1:0]        acc_im;
  logic signed [ACC_W-1:0]        scl_re;
  logic signed [ACC_W-1:0]        scl_im;
  logic signed [BIN_W-1:0]        bin_real;
  logic signed [BIN_W-1:0]        bin_imag;
  logic                           bin_last;

  // Handshake and sequencer status
  assign s_tready   = (state == S_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign store_full = load_count[PTS_W];
  assign k_done     = ((PTS_W + 1)'(k_idx) + (PTS_W + 1)'(1)) == count;
  assign drain_done = !v1 && !v2;
  assign bin_done   = (n_idx == PTS_W'(POINTS - 1));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (psel && penable && pwrite &&
                 paddr[CFG_ADDR_W-1:2] == REG_INVERSE_MODE) begin
      inverse_mode <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_INVERSE_MODE) begin
      prdata[0] = inverse_mode;
    end
  end

  // Sample store
  dftd_ram #(
    .WIDTH (IN_DATA_W),
    .DEPTH (POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && !store_full),
    .wr_addr (load_count[PTS_W-1:0]),
    .wr_data (s_tdata),
    .rd_en   (state == S_RUN),
    .rd_addr (k_idx),
    .rd_data (rd_word)
  );

  // Twiddle ROM, built at elaboration
  for (genvar g = 0; g < POINTS; g++) begin : g_rom
    assign cos_tab[g] = TWIDDLE_BITS'(tw_cos(g, PTS_W, TWIDDLE_BITS));
    assign sin_tab[g] = TWIDDLE_BITS'(tw_sin(g, PTS_W, TWIDDLE_BITS));
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN) begin
      cos_q <= cos_tab[m_idx];
      sin_q <= sin_tab[m_idx];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_tlast) begin
              count      <= store_full ? load_count : load_count + (PTS_W + 1)'(1);
              load_count <= '0;
              n_idx      <= '0;
              k_idx      <= '0;
              m_idx      <= '0;
              state      <= S_RUN;
            end else if (!store_full) begin
              load_count <= load_count + (PTS_W + 1)'(1);
            end
          end
        end
        S_RUN: begin
          if (k_done) begin
            state <= S_DRAIN;
          end else begin
            k_idx <= k_idx + PTS_W'(1);
            m_idx <= m_idx + n_idx;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (bin_done) begin
              state <= S_IDLE;
            end else begin
              n_idx <= n_idx + PTS_W'(1);
              k_idx <= '0;
              m_idx <= '0;
              state <= S_RUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Complex MAC operands: forward uses the conjugate twiddle
  assign op_a = rd_word[SAMPLE_W-1:0];
  assign op_b = rd_word[IN_DATA_W-1:SAMPLE_W];
  assign op_d = inverse_mode ? sin_q : -sin_q;

  // Scaling: floor by 2^TW_F, and by POINTS more in inverse mode
  assign scl_re = inverse_mode ? (acc_re >>> (TW_F + PTS_W)) : (acc_re >>> TW_F);
  assign scl_im = inverse_mode ? (acc_im >>> (TW_F + PTS_W)) : (acc_im >>> TW_F);

  // Datapath: products, accumulation, output register
  always_ff @(posedge clk) begin
    if (v1) begin
      pr_ac <= op_a * cos_q;
      pr_bd <= op_b * op_d;
      pr_ad <= op_a * op_d;
      pr_bc <= op_b * cos_q;
    end
    if ((state == S_IDLE && in_acc && s_tlast) ||
        (state == S_OUT && m_tready && !bin_done)) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + ACC_W'(pr_ac) - ACC_W'(pr_bd);
      acc_im <= acc_im + ACC_W'(pr_ad) + ACC_W'(pr_bc);
    end
    if (state == S_DRAIN && drain_done) begin
      bin_real <= (scl_re > BIN_HI) ? BIN_HI[BIN_W-1:0] :
                  (scl_re < BIN_LO) ? BIN_LO[BIN_W-1:0] : scl_re[BIN_W-1:0];
      bin_imag <= (scl_im > BIN_HI) ? BIN_HI[BIN_W-1:0] :
                  (scl_im < BIN_LO) ? BIN_LO[BIN_W-1:0] : scl_im[BIN_W-1:0];
      bin_last <= bin_done;
    end
  end

  assign m_tdata = {bin_imag, bin_real};
  assign m_tlast = bin_last;

  // Checks
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("sample port ready while a bin is pending");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("product stage valid without a read stage before it");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= (PTS_W + 1)'(POINTS))
    else $error("sample count beyond store depth");

  a_last_bin_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("sequencer not idle after final bin");

endmodule

// ===== tb/sv/tb_direct_dft_forward_inverse.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_dft_forward_inverse
// Streams blocks of complex samples into the direct DFT and checks every
// output bin against an in-bench transform built on its own twiddle table.
// Directed blocks cover the sample extremes, short and single-sample blocks,
// both directions and an unmapped register write. Random phases then mix full,
// short and overfull blocks under random idling on both streams, one phase
// without idling, and one long output hold-off that stalls the sample input.
// ----------------------------------------------------------------------------
module tb_direct_dft_forward_inverse;
  import dftd_pkg::*;

  localparam int POINTS   = POINTS_DEF;
  localparam int TW_BITS  = TWIDDLE_BITS_DEF;
  localparam int TW_FRAC  = TW_BITS - 1;
  localparam int PTS_LOG2 = $clog2(POINTS);

  // Phase arithmetic: turns scaled by 2^32, pi in Q2.30
  localparam longint unsigned PI_Q2_30   = 64'hC90F_DAA2;
  localparam longint unsigned QUARTER    = 64'h4000_0000;
  localparam longint unsigned TW_MAX     = (64'd1 << TW_FRAC) - 64'd1;
  localparam int              RND_SHIFT  = 30 - TW_FRAC;
  localparam longint          BIN_MAX    = (64'sd1 <<< (BIN_W - 1)) - 1;
  localparam longint          BIN_MIN    = -(64'sd1 <<< (BIN_W - 1));

  localparam logic [SAMPLE_W-1:0]  S_MAX        = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0]  S_MIN        = 16'h8000;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

  localparam int RANDOM_ITEMS = 310;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AFTER   = 200;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 100;

  typedef struct {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic                    last;
  } bin_t;

  // Transform predictor and store of expected bins
  class dft_scoreboard;
    logic signed [SAMPLE_W-1:0] re_store[POINTS];
    logic signed [SAMPLE_W-1:0] im_store[POINTS];
    int     cos_tab[POINTS];
    int     sin_tab[POINTS];
    int     loaded;
    bit     inverse;
    bin_t   expected_bins[$];
    int     errors;

    function new();
      bit [31:0] ph;
      for (int m = 0; m < POINTS; m++) begin
        ph = 32'(m) << (32 - PTS_LOG2);
        sin_tab[m] = round_twiddle(phase_sine(ph));
        cos_tab[m] = round_twiddle(phase_sine(ph + 32'(QUARTER)));
      end
      loaded  = 0;
      inverse = 1'b0;
      errors  = 0;
    endfunction

    // Eight-term Taylor sine in Q2.30, folded into the first quadrant
    function longint phase_sine(bit [31:0] ph);
      longint unsigned frac, x, x2, term;
      longint          acc;
      frac = {34'd0, ph[29:0]};
      if (ph[30]) frac = QUARTER - frac;
      x    = (frac * PI_Q2_30) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int i = 1; i <= 7; i++) begin
        term = ((term * x2) >> 30) / longint'(4 * i * i + 2 * i);
        acc  = (i % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      return ph[31] ? -acc : acc;
    endfunction

    // Q2.30 to twiddle format: round half away from zero, clamp magnitude
    function int round_twiddle(longint v);
      longint unsigned mag, r;
      mag = (v < 0) ? -v : v;
      r   = (mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
      if (r > TW_MAX) r = TW_MAX;
      return (v < 0) ? -int'(r) : int'(r);
    endfunction

    function logic signed [BIN_W-1:0] saturate(longint v);
      if (v > BIN_MAX) v = BIN_MAX;
      if (v < BIN_MIN) v = BIN_MIN;
      return v[BIN_W-1:0];
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_INVERSE_MODE) inverse = value[0];
    endfunction

    // Store one accepted sample; a last-marked one yields a full set of bins
    function void note_sample(logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im,
                              logic last);
      longint acc_re, acc_im, a, b, c, d;
      int     m, shift;
      bin_t   bin;
      if (loaded < POINTS) begin
        re_store[loaded] = re;
        im_store[loaded] = im;
        loaded++;
      end
      if (!last) return;
      shift = inverse ? TW_FRAC + PTS_LOG2 : TW_FRAC;
      for (int n = 0; n < POINTS; n++) begin
        acc_re = 0;
        acc_im = 0;
        // positions beyond the loaded count are zero padding
        for (int k = 0; k < loaded; k++) begin
          m = (n * k) % POINTS;
          a = re_store[k];
          b = im_store[k];
          c = cos_tab[m];
          d = inverse ? sin_tab[m] : -sin_tab[m];
          acc_re += a * c - b * d;
          acc_im += a * d + b * c;
        end
        bin.re   = saturate(acc_re >>> shift);
        bin.im   = saturate(acc_im >>> shift);
        bin.last = (n == POINTS - 1);
        expected_bins.push_back(bin);
      end
      loaded = 0;
    endfunction

    function void check_bin(logic [BIN_W-1:0] re, logic [BIN_W-1:0] im, logic last);
      bin_t exp_bin;
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected bin re=%0d im=%0d last=%0b", $time,
                 $signed(re), $signed(im), last);
        errors++;
        return;
      end
      exp_bin = expected_bins.pop_front();
      if (re !== exp_bin.re) begin
        $display("%0t: bin_real expected %0d actual %0d", $time, exp_bin.re, $signed(re));
        errors++;
      end
      if (im !== exp_bin.im) begin
        $display("%0t: bin_imag expected %0d actual %0d", $time, exp_bin.im, $signed(im));
        errors++;
      end
      if (last !== exp_bin.last) begin
        $display("%0t: bin_last expected %0b actual %0b", $time, exp_bin.last, last);
        errors++;
      end
    endfunction

    function int waiting();
      return expected_bins.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // sample_real, sample_imag
  logic                  s_tlast;   // sample_last
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // bin_real, bin_imag
  logic                  m_tlast;   // bin_last
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  dft_scoreboard sb;
  bit            steady;
  bit            hold_done;
  int            bins_taken;

  direct_dft_forward_inverse #(
    .POINTS      (POINTS),
    .TWIDDLE_BITS(TW_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.note_sample(s_tdata[SAMPLE_W-1:0], s_tdata[IN_DATA_W-1:SAMPLE_W], s_tlast);
    end
  end

  // Bin receiver: checks each item, random stalls, one long hold-off
  initial begin : bin_sink
    int hold_left;
    hold_left  = 0;
    hold_done  = 1'b0;
    bins_taken = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_bin(m_tdata[BIN_W-1:0], m_tdata[OUT_DATA_W-1:BIN_W], m_tlast);
        bins_taken++;
      end
      // hold off while the sender is blocked so the block backs up fully
      if (!hold_done && bins_taken >= HOLD_AFTER && s_tvalid && !s_tready) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // Watchdog on cycles without any accepted item or register access
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("** direct_dft_forward_inverse: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im,
                             input logic last);
    while (!steady && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {im, re};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering, let the monitor note the final sample, wait for every
  // expected bin, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int items_sent, len, phase;
    sb       = new();
    steady   = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Forward: single-sample block, then an eight-sample block of extremes
    write_reg(REG_INVERSE_MODE, 32'd0);
    send_sample(S_MAX, S_MIN, 1'b1);
    send_sample(S_MIN, S_MAX, 1'b0);
    send_sample(S_MAX, S_MAX, 1'b0);
    send_sample(S_MIN, S_MIN, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0001, 16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 16'h0001, 1'b0);
    send_sample(16'h5555, 16'hAAAA, 1'b0);
    send_sample(16'hAAAA, 16'h5555, 1'b1);
    drain();

    // Unmapped register write must leave the direction alone
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_sample(S_MIN, S_MIN, 1'b1);
    drain();

    // Inverse: corners, then a single sample
    write_reg(REG_INVERSE_MODE, 32'hFFFF_FFFF);
    send_sample(S_MAX, S_MAX, 1'b0);
    send_sample(S_MIN, S_MAX, 1'b0);
    send_sample(S_MAX, S_MIN, 1'b0);
    send_sample(S_MIN, S_MIN, 1'b1);
    send_sample(S_MIN, S_MAX, 1'b1);
    drain();

    // Random phases of back-to-back blocks, direction set anew for each phase
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (phase == 1);
      write_reg(REG_INVERSE_MODE, (phase < 2) ? 32'(phase) : 32'($urandom_range(0, 1)));
      repeat ($urandom_range(2, 4)) begin
        if (items_sent >= RANDOM_ITEMS) break;
        case ($urandom_range(0, 99)) inside
          [0:14]:  len = POINTS;
          [15:24]: len = $urandom_range(POINTS + 1, POINTS + 8);  // overfull
          [25:44]: len = $urandom_range(1, 8);
          default: len = $urandom_range(9, POINTS - 1);
        endcase
        for (int i = 0; i < len; i++) begin
          send_sample(pick_sample(), pick_sample(), i == len - 1);
        end
        items_sent += len;
      end
      drain();
      phase++;
    end
    steady = 1'b0;

    drain();
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** direct_dft_forward_inverse: PASSED **");
    end else begin
      $display("** direct_dft_forward_inverse: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dftd_pkg.sv
rtl/dftd_ram.sv
rtl/direct_dft_forward_inverse.sv
tb/sv/tb_direct_dft_forward_inverse.sv
